### hdl/kcg_pkg.sv
package kcg_pkg;

  // largest set size the generator supports
  localparam int unsigned MAX_SET = 32;

  // fixed field widths
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // internal widths derived from the set size
  localparam int unsigned SEL_W = MAX_SET;
  localparam int unsigned CNT_W = $clog2(MAX_SET + 1);
  localparam int unsigned POS_W = $clog2(MAX_SET);

  // reset values of the registers
  localparam logic [CFG_W-1:0] SET_SIZE_RST  = CFG_W'(25);
  localparam logic [CFG_W-1:0] PICK_SIZE_RST = CFG_W'(15);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SIZE  = 1'b0,
    REG_PICK_SIZE = 1'b1
  } kcg_reg_e;

  // effective sizes handed to the core
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
  } kcg_cfg_t;

  // word held in the input stage
  typedef struct packed {
    logic vld;
    logic restart;
  } kcg_in_t;

  // result word
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              valid_res;
    logic              last;
  } kcg_res_t;

  // clamp a register value to MAX_SET
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CFG_W-1:0] v);
    logic [CNT_W+CFG_W-1:0] ext;
    ext = (CNT_W + CFG_W)'(v);
    if (ext > (CNT_W + CFG_W)'(MAX_SET)) begin
      return CNT_W'(MAX_SET);
    end
    return CNT_W'(v);
  endfunction

  // mask with the low len bits set
  function automatic logic [SEL_W-1:0] ones(input logic [CNT_W-1:0] len);
    logic [SEL_W:0] t;
    t = ((SEL_W + 1)'(1) << len) - (SEL_W + 1)'(1);
    return t[SEL_W-1:0];
  endfunction

endpackage

### hdl/kcg_cfg.sv
module kcg_cfg import kcg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output kcg_cfg_t             cfg_o
);

  logic [CFG_W-1:0] set_size_q, set_size_d;
  logic [CFG_W-1:0] pick_size_q, pick_size_d;

  // register write decode
  always_comb begin
    set_size_d  = set_size_q;
    pick_size_d = pick_size_q;
    if (cfg_we_i) begin
      unique case (kcg_reg_e'(cfg_idx_i))
        REG_SET_SIZE:  set_size_d  = cfg_wdata_i;
        REG_PICK_SIZE: pick_size_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q  <= SET_SIZE_RST;
      pick_size_q <= PICK_SIZE_RST;
    end else begin
      set_size_q  <= set_size_d;
      pick_size_q <= pick_size_d;
    end
  end

  // saturated sizes and write strobe
  assign cfg_o.wr = cfg_we_i;
  assign cfg_o.n  = sat_cnt(set_size_q);
  assign cfg_o.k  = sat_cnt(pick_size_q);

endmodule

### hdl/kcg_in_reg.sv
module kcg_in_reg import kcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    restart_i,
  input  logic    fire_i,
  output kcg_in_t word_o
);

  logic vld_q, vld_d;
  logic restart_q, restart_d;
  logic accept;

  // stage frees up when its word moves on
  assign in_ready_o = !vld_q || fire_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d     = vld_q;
    restart_d = restart_q;
    if (accept) begin
      vld_d     = 1'b1;
      restart_d = restart_i;
    end else if (fire_i) begin
      vld_d = 1'b0;
    end
  end

  // control bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    restart_q <= restart_d;
  end

  assign word_o.vld     = vld_q;
  assign word_o.restart = restart_q;

endmodule

### hdl/kcg_core.sv
module kcg_core import kcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  kcg_cfg_t cfg_i,
  input  logic     fire_i,
  input  logic     restart_i,
  output kcg_res_t res_o
);

  logic [SEL_W-1:0] sel_q, sel_d;
  logic             started_q, started_d;
  logic             exhausted_q, exhausted_d;

  logic [SEL_W-1:0] first_mask, top_mask, n_mask, upper, cand, next_mask;
  logic [POS_W-1:0] h_pos, p_pos;
  logic             h_found, p_found, can_move;
  logic [CNT_W-1:0] run_len;
  logic             k_gt_n;
  logic             emit;
  logic [SEL_W-1:0] emit_mask;
  logic             is_last;

  // masks that follow from n and k
  assign k_gt_n     = cfg_i.k > cfg_i.n;
  assign first_mask = ones(cfg_i.k);
  assign top_mask   = first_mask << (cfg_i.n - cfg_i.k);
  assign n_mask     = ones(cfg_i.n);

  // highest free slot: everything above it is the block packed at the top
  assign upper = sel_q | ~n_mask;
  always_comb begin
    h_pos   = '0;
    h_found = 1'b0;
    for (int i = 0; i < SEL_W; i++) begin
      if (!upper[i]) begin
        h_pos   = POS_W'(i);
        h_found = 1'b1;
      end
    end
  end

  // highest member below that slot is the one that moves up
  assign cand = sel_q & ones(CNT_W'(h_pos));
  always_comb begin
    p_pos   = '0;
    p_found = 1'b0;
    for (int i = 0; i < SEL_W; i++) begin
      if (cand[i]) begin
        p_pos   = POS_W'(i);
        p_found = 1'b1;
      end
    end
  end

  // moved member and the top block pack right after its old place
  assign can_move  = h_found && p_found;
  assign run_len   = cfg_i.n - CNT_W'(h_pos);
  assign next_mask = (sel_q & ones(CNT_W'(p_pos)))
                   | (ones(run_len) << (CNT_W'(p_pos) + CNT_W'(1)));

  // step decision
  always_comb begin
    sel_d       = sel_q;
    started_d   = started_q;
    exhausted_d = exhausted_q;
    emit        = 1'b0;
    emit_mask   = '0;
    if (fire_i) begin
      if (restart_i || !started_q) begin
        started_d   = 1'b1;
        exhausted_d = k_gt_n;
        if (!k_gt_n) begin
          sel_d     = first_mask;
          emit      = 1'b1;
          emit_mask = first_mask;
        end
      end else if (!exhausted_q && !k_gt_n && (cfg_i.k != '0) && can_move) begin
        sel_d     = next_mask;
        emit      = 1'b1;
        emit_mask = next_mask;
      end else begin
        exhausted_d = 1'b1;
      end
      if (emit && (emit_mask == top_mask)) begin
        exhausted_d = 1'b1;
      end
    end
    // a register write starts a fresh enumeration
    if (cfg_i.wr) begin
      started_d = 1'b0;
    end
  end

  assign is_last = emit && (emit_mask == top_mask);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      exhausted_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      exhausted_q <= exhausted_d;
    end
  end

  // current subset
  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
  end

  assign res_o.mask      = MASK_W'(emit_mask);
  assign res_o.valid_res = emit;
  assign res_o.last      = is_last;

endmodule

### hdl/kcg_out_reg.sv
module kcg_out_reg import kcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  kcg_res_t res_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kcg_res_t res_o
);

  logic     vld_q, vld_d;
  kcg_res_t res_q, res_d;

  // room when empty or the word leaves this cycle
  assign space_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (fire_i) begin
      vld_d = 1'b1;
      res_d = res_i;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

### hdl/k_combination_generator.sv
// Lexicographic k-combination generator. Each input word either restarts the
// enumeration at the first subset {0..k-1} or advances to the next k-subset of
// n positions, and each one yields exactly one result word: the subset as a
// selection mask, a flag on the final subset, and valid_res low once the
// enumeration is exhausted or when k exceeds n (mask and last are then zero).
// n and k come from two registers written through the config port; the user
// must write them only while the block is idle, which the block does not
// enforce. Values above 32 clamp to 32, and any write starts a fresh
// enumeration on the next input word. Throughput is one word per clock while
// out_ready_i is high: the next subset is found in the same cycle by a
// priority search over the current mask register, which together with a
// started and an exhausted flag is the only state carried from word to word.
// A word passes the input register and then the result register before its
// result is presented, and one more input word is taken while a result waits.
module k_combination_generator import kcg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MASK_W-1:0]    selection_mask_o,
  output logic                 valid_res_o,
  output logic                 last_o
);

  kcg_cfg_t cfg;
  kcg_in_t  in_word;
  kcg_res_t core_res, out_res;
  logic     out_space;
  logic     fire;

  // word moves from input stage to result stage
  assign fire = in_word.vld && out_space;

  kcg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kcg_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .fire_i     (fire),
    .word_o     (in_word)
  );

  kcg_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .restart_i (in_word.restart),
    .res_o     (core_res)
  );

  kcg_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (core_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign selection_mask_o = out_res.mask;
  assign valid_res_o      = out_res.valid_res;
  assign last_o           = out_res.last;

endmodule

### hdl/kcg_checker.sv
module kcg_checker import kcg_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [MASK_W-1:0]    selection_mask_o,
  input logic                 valid_res_o,
  input logic                 last_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(selection_mask_o) && $stable(valid_res_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // an empty result carries no mask and no last flag
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> selection_mask_o == '0 && !last_o)
    else $error("empty result with mask or last set");

  // last only on a real subset
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> valid_res_o)
    else $error("last flag on an empty result");

  // input only blocks behind a waiting result
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked with no result waiting");

endmodule

bind k_combination_generator kcg_checker u_kcg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .selection_mask_o (selection_mask_o),
  .valid_res_o      (valid_res_o),
  .last_o           (last_o)
);

### tb/sv/k_combination_generator_tb.sv
`timescale 1ns / 100ps

module k_combination_generator_tb;
  import kcg_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // tracks the expected subset enumeration and checks result words
  class subset_scoreboard;
    logic [CFG_W-1:0] set_size;
    logic [CFG_W-1:0] pick_size;
    logic [CNT_W-1:0] pos [MAX_SET];
    bit               started;
    bit               exhausted;
    kcg_res_t         subset_q [$];
    int               errors;
    int               words_in;
    int               subsets_seen;
    int               finals_seen;
    int               empty_seen;
    int               settings;

    function new();
      set_size  = SET_SIZE_RST;
      pick_size = PICK_SIZE_RST;
      started   = 1'b0;
      exhausted = 1'b0;
      errors    = 0;
      words_in  = 0;
      subsets_seen = 0;
      finals_seen  = 0;
      empty_seen   = 0;
      settings     = 0;
      load_first(int'(PICK_SIZE_RST));
    endfunction

    // ascending positions 0..k-1, rest zero
    function void load_first(int k);
      for (int i = 0; i < MAX_SET; i++) begin
        pos[i] = (i < k) ? CNT_W'(i) : '0;
      end
    endfunction

    function int pending();
      return subset_q.size();
    endfunction

    // any register write begins a fresh enumeration
    function void write_reg(kcg_reg_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_SET_SIZE) begin
        set_size = value;
      end else begin
        pick_size = value;
      end
      started = 1'b0;
    endfunction

    // work out the result word caused by one accepted input word
    function void note_input(logic restart);
      int       n;
      int       k;
      int       i;
      bit       emit;
      bit       found;
      bit       fin;
      kcg_res_t res;
      n = (int'(set_size) > MAX_SET) ? MAX_SET : int'(set_size);
      k = (int'(pick_size) > MAX_SET) ? MAX_SET : int'(pick_size);
      emit  = 1'b0;
      found = 1'b0;
      res   = '0;
      words_in++;
      if (restart || !started) begin
        started   = 1'b1;
        exhausted = 1'b0;
        if (k > n) begin
          exhausted = 1'b1;
        end else begin
          load_first(k);
          emit = 1'b1;
        end
      end else if (!exhausted && k <= n && k > 0) begin
        // rightmost position that can still move right
        i = k;
        while (i > 0 && !found) begin
          i--;
          if (int'(pos[i]) < n - k + i) found = 1'b1;
        end
        if (found) begin
          pos[i] = pos[i] + 1'b1;
          for (int j = i + 1; j < k; j++) begin
            pos[j] = pos[j-1] + 1'b1;
          end
          emit = 1'b1;
        end else begin
          exhausted = 1'b1;
        end
      end else begin
        exhausted = 1'b1;
      end
      if (emit) begin
        for (int m = 0; m < k; m++) begin
          res.mask[pos[m]] = 1'b1;
        end
        fin = (k == 0) || (int'(pos[0]) == n - k);
        res.valid_res = 1'b1;
        res.last      = fin;
        if (fin) exhausted = 1'b1;
      end
      subset_q = {subset_q, res};
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(kcg_res_t got);
      kcg_res_t want;
      if (subset_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = subset_q.pop_front();
      if (want.valid_res) subsets_seen++;
      else empty_seen++;
      if (want.last) finals_seen++;
      if (got.mask !== want.mask) begin
        $display("%0t: selection_mask mismatch: expected %h actual %h",
                 $time, want.mask, got.mask);
        errors++;
      end
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res mismatch: expected %b actual %b",
                 $time, want.valid_res, got.valid_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [MASK_W-1:0]    selection_mask_o;
  logic                 valid_res_o;
  logic                 last_o;

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 71;
  int unsigned stall_cycles  = 0;

  subset_scoreboard sb = new();

  k_combination_generator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .selection_mask_o (selection_mask_o),
    .valid_res_o      (valid_res_o),
    .last_o           (last_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at random
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
      @(posedge clk_i);
    end
  end

  // result words are stable from negedge to the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({selection_mask_o, valid_res_o, last_o});
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // offer one input word, with a random gap first
  task automatic send_word(input logic restart_bit);
    bit took;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart_bit;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    sb.note_input(restart_bit);
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write both size registers while the block is idle
  task automatic set_sizes(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SET_SIZE;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    sb.write_reg(REG_SET_SIZE, n);
    cfg_idx_i   <= REG_PICK_SIZE;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    sb.write_reg(REG_PICK_SIZE, k);
    cfg_we_i <= 1'b0;
    sb.settings++;
  endtask

  // one random setting followed by a mostly well-formed walk
  task automatic random_walk();
    int n;
    int k;
    int sel;
    int cap;
    int count;
    sel = $urandom_range(99, 0);
    if (sel < 60) begin
      n = $urandom_range(8, 1);
      k = $urandom_range(n + 1, 0);
    end else if (sel < 80) begin
      n = $urandom_range(32, 9);
      k = $urandom_range(n, 1);
    end else begin
      n = $urandom_range(63, 0);
      k = $urandom_range(63, 0);
    end
    set_sizes(CFG_W'(n), CFG_W'(k));
    cap = $urandom_range(80, 4);
    // most walks open with a restart, some rely on the first advance
    send_word($urandom_range(3, 0) != 0);
    count = 1;
    while (!sb.exhausted && count < cap) begin
      send_word($urandom_range(19, 0) == 0);
      count++;
    end
    // a few words past the end of the enumeration
    repeat ($urandom_range(2, 0)) send_word($urandom_range(1, 0) != 0);
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes, advance before any start, then a mid-walk restart
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    // full walk of 4 choose 2, exhaust, then restart after exhaustion
    set_sizes(6'd4, 6'd2);
    repeat (7) send_word(1'b0);
    send_word(1'b1);
    // k equal to n
    set_sizes(6'd5, 6'd5);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    // k of zero
    set_sizes(6'd3, 6'd0);
    send_word(1'b1);
    send_word(1'b0);
    // k exceeds n
    set_sizes(6'd3, 6'd4);
    send_word(1'b1);
    send_word(1'b0);
    // both registers above the largest set size
    set_sizes(6'd63, 6'd63);
    send_word(1'b1);
    send_word(1'b0);
    // n saturates, walk near the top
    set_sizes(6'd33, 6'd31);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    // smallest sets
    set_sizes(6'd1, 6'd1);
    send_word(1'b1);
    set_sizes(6'd0, 6'd0);
    send_word(1'b0);

    // random walks under three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 71;
        recv_idle_pct = 24;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (sb.words_in < 25 + 475 * (phase + 1)) random_walk();
    end

    drain();
    $display("covered %0d input words over %0d size settings", sb.words_in, sb.settings);
    $display("%0d subsets checked, %0d final subsets, %0d not-valid words",
             sb.subsets_seen, sb.finals_seen, sb.empty_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
